FILE: hdl/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, held off during reset.
`define SPQ_ASSERT_NOW(name, clk_i, rstn_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("sorted_priority_queue: assertion failed");

// Next-cycle implication, held off during reset.
`define SPQ_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("sorted_priority_queue: assertion failed");

`else

`define SPQ_ASSERT_NOW(name, clk_i, rstn_i, ante, cons)
`define SPQ_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons)

`endif

`endif

FILE: hdl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Command codes carried on the input tuser
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_REM = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_NOMATCH = 2'd2,
    STAT_FULL    = 2'd3
  } spq_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_CMP,
    ST_REM_SCAN,
    ST_REM_SHIFT,
    ST_HEAD_RD,
    ST_HEAD_LD,
    ST_OUT
  } spq_state_t;

  // Flags from the shared priority comparator
  typedef struct packed {
    logic gt;   // slot priority above the requested one
    logic eq;   // slot priority equal to the requested one
  } spq_cmp_t;

endpackage

`default_nettype wire

FILE: hdl/sorted_priority_queue.sv
// Sorted priority queue: a small slot memory kept in ascending priority order
// by a sequencer that walks it one entry per cycle through a shared
// comparator. An enqueue starts at the tail and moves every entry of higher
// priority up one slot until it finds its place, so equal priorities leave in
// arrival order; a removal scans from the head for the first entry of the
// named priority and closes the gap behind it. An enqueue walks down from the
// tail and stops where the new entry lands; a removal walks from the head to
// the tail; a refused or empty request does not walk the slots. Each walk goes
// over the single read port of the slot memory, and the block is ready again
// in the cycle after the result transfer. One command is in progress at a
// time: in_tready is high only while the block is idle, and each command
// gives one result with the status, the new count and the head entry.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int VALUE_BITS    = 16,
  parameter int PRIORITY_BITS = 8,
  localparam int IDX_W        = $clog2(DEPTH),
  localparam int CNT_W        = $clog2(DEPTH + 1),
  localparam int IN_DW        = ((VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8,
  localparam int OUT_DW       = ((CNT_W + 1 + VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // item_value, priority_req, zero pad
  input  wire logic              in_tuser,   // action
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_DW-1:0] out_tdata,  // entry_count, head_valid, head_value,
                                             // head_priority, zero pad
  output logic      [1:0]        out_tuser   // status
);

  logic [VALUE_BITS-1:0]    in_val;
  logic [PRIORITY_BITS-1:0] in_pri;

  spq_pkg::spq_status_t     res_status;
  logic [CNT_W-1:0]         res_count;
  logic                     res_head_valid;
  logic [VALUE_BITS-1:0]    res_head_val;
  logic [PRIORITY_BITS-1:0] res_head_pri;

  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0]    mem_wval;
  logic [PRIORITY_BITS-1:0] mem_wpri;
  logic [IDX_W-1:0]         mem_raddr;
  logic [VALUE_BITS-1:0]    mem_rval;
  logic [PRIORITY_BITS-1:0] mem_rpri;

  logic [PRIORITY_BITS-1:0] cmp_req_pri;
  spq_pkg::spq_cmp_t        cmp_res;

  // Unpack the command
  assign in_val = in_tdata[VALUE_BITS-1:0];
  assign in_pri = in_tdata[VALUE_BITS +: PRIORITY_BITS];

  // Pack the result
  assign out_tdata = OUT_DW'({res_head_pri, res_head_val, res_head_valid, res_count});
  assign out_tuser = res_status;

  spq_ctrl #(
    .DEPTH         (DEPTH),
    .VALUE_BITS    (VALUE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_act         (in_tuser),
    .in_val         (in_val),
    .in_pri         (in_pri),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_status     (res_status),
    .out_count      (res_count),
    .out_head_valid (res_head_valid),
    .out_head_val   (res_head_val),
    .out_head_pri   (res_head_pri),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wval       (mem_wval),
    .mem_wpri       (mem_wpri),
    .mem_raddr      (mem_raddr),
    .mem_rval       (mem_rval),
    .mem_rpri       (mem_rpri),
    .cmp_req_pri    (cmp_req_pri),
    .cmp_res        (cmp_res)
  );

  spq_slot_ram #(
    .DEPTH         (DEPTH),
    .VALUE_BITS    (VALUE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wval  (mem_wval),
    .wpri  (mem_wpri),
    .raddr (mem_raddr),
    .rval  (mem_rval),
    .rpri  (mem_rpri)
  );

  spq_cmp #(
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_cmp (
    .slot_pri (mem_rpri),
    .req_pri  (cmp_req_pri),
    .res      (cmp_res)
  );

endmodule

`default_nettype wire

FILE: hdl/spq_slot_ram.sv
// Slot storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module spq_slot_ram #(
  parameter int DEPTH         = 16,
  parameter int VALUE_BITS    = 16,
  parameter int PRIORITY_BITS = 8,
  localparam int IDX_W        = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [IDX_W-1:0]         waddr,
  input  wire logic [VALUE_BITS-1:0]    wval,
  input  wire logic [PRIORITY_BITS-1:0] wpri,
  input  wire logic [IDX_W-1:0]         raddr,
  output logic      [VALUE_BITS-1:0]    rval,
  output logic      [PRIORITY_BITS-1:0] rpri
);

  logic [VALUE_BITS-1:0]    val_mem [DEPTH];
  logic [PRIORITY_BITS-1:0] pri_mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      val_mem[waddr] <= wval;
      pri_mem[waddr] <= wpri;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rval <= val_mem[raddr];
    rpri <= pri_mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/spq_cmp.sv
// Shared priority comparator used by every scan step.
`timescale 1ns / 1ps
`default_nettype none

module spq_cmp #(
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic [PRIORITY_BITS-1:0] slot_pri,
  input  wire logic [PRIORITY_BITS-1:0] req_pri,
  output spq_pkg::spq_cmp_t             res
);

  assign res.gt = (slot_pri > req_pri);
  assign res.eq = (slot_pri == req_pri);

endmodule

`default_nettype wire

FILE: hdl/spq_ctrl.sv
// Sequencer: insertion, search-and-remove, head fetch and result register.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module spq_ctrl #(
  parameter int DEPTH         = 16,
  parameter int VALUE_BITS    = 16,
  parameter int PRIORITY_BITS = 8,
  localparam int IDX_W        = $clog2(DEPTH),
  localparam int CNT_W        = $clog2(DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // command side
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_act,
  input  wire logic [VALUE_BITS-1:0]    in_val,
  input  wire logic [PRIORITY_BITS-1:0] in_pri,
  // result side
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output spq_pkg::spq_status_t          out_status,
  output logic      [CNT_W-1:0]         out_count,
  output logic                          out_head_valid,
  output logic      [VALUE_BITS-1:0]    out_head_val,
  output logic      [PRIORITY_BITS-1:0] out_head_pri,
  // slot storage
  output logic                          mem_we,
  output logic      [IDX_W-1:0]         mem_waddr,
  output logic      [VALUE_BITS-1:0]    mem_wval,
  output logic      [PRIORITY_BITS-1:0] mem_wpri,
  output logic      [IDX_W-1:0]         mem_raddr,
  input  wire logic [VALUE_BITS-1:0]    mem_rval,
  input  wire logic [PRIORITY_BITS-1:0] mem_rpri,
  // comparator
  output logic      [PRIORITY_BITS-1:0] cmp_req_pri,
  input  wire spq_pkg::spq_cmp_t        cmp_res
);

  spq_pkg::spq_state_t  state_r, state_nxt;
  spq_pkg::spq_status_t stat_r, stat_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     act_r, act_nxt;
  logic [VALUE_BITS-1:0]    val_r, val_nxt;
  logic [PRIORITY_BITS-1:0] pri_r, pri_nxt;
  spq_pkg::spq_status_t     ostat_r, ostat_nxt;
  logic [CNT_W-1:0]         ocnt_r, ocnt_nxt;
  logic                     ohv_r, ohv_nxt;
  logic [VALUE_BITS-1:0]    oval_r, oval_nxt;
  logic [PRIORITY_BITS-1:0] opri_r, opri_nxt;

  logic [CNT_W-1:0] fill_dec;
  logic [IDX_W-1:0] last_idx;
  logic             full;
  logic             at_last;

  assign fill_dec = fill_r - CNT_W'(1);
  assign last_idx = fill_dec[IDX_W-1:0];
  assign full     = (fill_r == CNT_W'(DEPTH));
  assign at_last  = (idx_r == last_idx);

  assign in_ready       = (state_r == spq_pkg::ST_IDLE);
  assign out_valid      = (state_r == spq_pkg::ST_OUT);
  assign out_status     = ostat_r;
  assign out_count      = ocnt_r;
  assign out_head_valid = ohv_r;
  assign out_head_val   = oval_r;
  assign out_head_pri   = opri_r;
  assign cmp_req_pri    = pri_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    stat_r  <= stat_nxt;
    act_r   <= act_nxt;
    val_r   <= val_nxt;
    pri_r   <= pri_nxt;
    ostat_r <= ostat_nxt;
    ocnt_r  <= ocnt_nxt;
    ohv_r   <= ohv_nxt;
    oval_r  <= oval_nxt;
    opri_r  <= opri_nxt;
  end

  // Next state and storage control
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    stat_nxt  = stat_r;
    act_nxt   = act_r;
    val_nxt   = val_r;
    pri_nxt   = pri_r;
    ostat_nxt = ostat_r;
    ocnt_nxt  = ocnt_r;
    ohv_nxt   = ohv_r;
    oval_nxt  = oval_r;
    opri_nxt  = opri_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wval  = val_r;
    mem_wpri  = pri_r;
    mem_raddr = idx_r + IDX_W'(1);

    unique case (state_r)
      spq_pkg::ST_IDLE: begin
        if (in_valid) begin
          act_nxt = in_act;
          val_nxt = in_val;
          pri_nxt = in_pri;
          if (in_act == spq_pkg::ACT_ENQ) begin
            if (full) begin
              stat_nxt  = spq_pkg::STAT_FULL;
              state_nxt = spq_pkg::ST_HEAD_RD;
            end else begin
              // hole starts past the tail; fetch the tail entry
              idx_nxt   = fill_r[IDX_W-1:0];
              mem_raddr = last_idx;
              state_nxt = spq_pkg::ST_ENQ_CMP;
            end
          end else begin
            if (fill_r == '0) begin
              stat_nxt  = spq_pkg::STAT_EMPTY;
              state_nxt = spq_pkg::ST_HEAD_RD;
            end else begin
              idx_nxt   = '0;
              mem_raddr = '0;
              state_nxt = spq_pkg::ST_REM_SCAN;
            end
          end
        end
      end

      // read data holds the entry just below the hole
      spq_pkg::ST_ENQ_CMP: begin
        mem_we = 1'b1;
        if (idx_r == '0 || !cmp_res.gt) begin
          fill_nxt  = fill_r + CNT_W'(1);
          stat_nxt  = spq_pkg::STAT_DONE;
          state_nxt = spq_pkg::ST_HEAD_RD;
        end else begin
          // move the larger entry up one and lower the hole
          mem_wval  = mem_rval;
          mem_wpri  = mem_rpri;
          idx_nxt   = idx_r - IDX_W'(1);
          mem_raddr = idx_r - IDX_W'(2);
        end
      end

      // read data holds the entry at idx_r
      spq_pkg::ST_REM_SCAN: begin
        if (cmp_res.eq) begin
          if (at_last) begin
            fill_nxt  = fill_dec;
            stat_nxt  = spq_pkg::STAT_DONE;
            state_nxt = spq_pkg::ST_HEAD_RD;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = spq_pkg::ST_REM_SHIFT;
          end
        end else if (at_last) begin
          stat_nxt  = spq_pkg::STAT_NOMATCH;
          state_nxt = spq_pkg::ST_HEAD_RD;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // close the gap: entry at idx_r moves down one
      spq_pkg::ST_REM_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r - IDX_W'(1);
        mem_wval  = mem_rval;
        mem_wpri  = mem_rpri;
        if (at_last) begin
          fill_nxt  = fill_dec;
          stat_nxt  = spq_pkg::STAT_DONE;
          state_nxt = spq_pkg::ST_HEAD_RD;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      spq_pkg::ST_HEAD_RD: begin
        mem_raddr = '0;
        state_nxt = spq_pkg::ST_HEAD_LD;
      end

      // load the result register
      spq_pkg::ST_HEAD_LD: begin
        ostat_nxt = stat_r;
        ocnt_nxt  = fill_r;
        ohv_nxt   = (fill_r != '0);
        oval_nxt  = (fill_r != '0) ? mem_rval : '0;
        opri_nxt  = (fill_r != '0) ? mem_rpri : '0;
        state_nxt = spq_pkg::ST_OUT;
      end

      spq_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = spq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks on the sequencer
  `SPQ_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CNT_W'(DEPTH))
  `SPQ_ASSERT_NOW(a_we_state, clk, rst_n, mem_we,
                  (state_r == spq_pkg::ST_ENQ_CMP) || (state_r == spq_pkg::ST_REM_SHIFT))
  `SPQ_ASSERT_NOW(a_enq_not_full, clk, rst_n, state_r == spq_pkg::ST_ENQ_CMP, !full)
  `SPQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready,
                   state_r != spq_pkg::ST_IDLE)
  `SPQ_ASSERT_NOW(a_full_status, clk, rst_n,
                  (state_r == spq_pkg::ST_HEAD_LD) && (stat_r == spq_pkg::STAT_FULL) &&
                  (act_r == spq_pkg::ACT_ENQ), full)

endmodule

`default_nettype wire
